### rtl/core/tcw_pkg.sv
// Shared constants, types and address helpers for the text console writer.
package tcw_pkg;

    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int NUM_CELLS = COLUMNS * ROWS;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(NUM_CELLS);

    localparam int MODE_W      = 2;
    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int CELL_W      = CHAR_W + ATTR_W;
    localparam int ROW_FIELD_W = 5;
    localparam int COL_FIELD_W = 7;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'd32;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd15;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUT   = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2
    } mode_t;

    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   waddr;
        logic [CELL_W-1:0]   wdata;
        logic                re;
        logic [ADDR_W-1:0]   raddr;
    } mem_req_t;

    typedef struct packed {
        logic [CHAR_W-1:0]      cell_char;
        logic [ATTR_W-1:0]      cell_attr;
        logic [ROW_FIELD_W-1:0] cursor_row;
        logic [COL_FIELD_W-1:0] cursor_col;
        logic                   did_scroll;
    } result_t;

    // logical row -> physical row of the circular row store
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
                                                  input logic [ROW_W-1:0] row);
        logic [ROW_W:0] sum;
        sum = {1'b0, top} + {1'b0, row};
        if (sum >= (ROW_W+1)'(ROWS))
        begin
            sum = sum - (ROW_W+1)'(ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

endpackage

### rtl/core/tcw_ram.sv
// Single-port-write, single-port-read cell memory with registered read data.
module tcw_ram #(
    parameter int DEPTH = 2000,
    parameter int WIDTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_reg <= mem[raddr];
        end
    end

    assign rdata = rd_reg;

endmodule

### rtl/core/tcw_ctrl.sv
// Request sequencer: cursor, row rotation, memory sweeps and result assembly.
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [MODE_W-1:0]      mode,
    input  logic [CHAR_W-1:0]      char_code,
    input  logic [ROW_FIELD_W-1:0] read_row,
    input  logic [COL_FIELD_W-1:0] read_col,
    input  logic [ATTR_W-1:0]      attr,
    input  logic                   slot_free,
    output logic                   res_valid,
    output result_t                res,
    output mem_req_t               mem_req,
    input  logic [CELL_W-1:0]      rdata
);

    typedef enum logic [6:0] {
        S_INIT   = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_EXEC   = 7'b0000100,
        S_RWAIT  = 7'b0001000,
        S_CLEAR  = 7'b0010000,
        S_SCROLL = 7'b0100000,
        S_POST   = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic [ROW_W-1:0]   rrow_reg, rrow_next;
    logic [COL_W-1:0]   rcol_reg, rcol_next;
    logic               in_range_reg, in_range_next;
    logic [ROW_W-1:0]   cur_row_reg, cur_row_next;
    logic [COL_W-1:0]   cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]   top_reg, top_next;
    logic [ADDR_W-1:0]  sweep_addr_reg, sweep_addr_next;
    logic [COL_W-1:0]   sweep_col_reg, sweep_col_next;
    logic               scroll_reg, scroll_next;
    logic [CHAR_W-1:0]  rd_char_reg, rd_char_next;
    logic [ATTR_W-1:0]  rd_attr_reg, rd_attr_next;

    logic               accept;
    logic               req_in_range;
    logic               is_nl;
    logic               wrap;
    logic               adv_row;
    logic               scroll;
    logic [CELL_W-1:0]  blank;

    assign in_ready     = (state_reg == S_IDLE) || ((state_reg == S_POST) && slot_free);
    assign accept       = in_valid && in_ready;
    assign res_valid    = (state_reg == S_POST);
    assign req_in_range = (32'(read_row) < ROWS) && (32'(read_col) < COLUMNS);
    assign blank        = {attr, BLANK_CODE};

    assign is_nl   = (char_reg == NEWLINE_CODE);
    assign wrap    = !is_nl && (cur_col_reg == COL_W'(COLUMNS - 1));
    assign adv_row = is_nl || wrap;
    assign scroll  = adv_row && (cur_row_reg == ROW_W'(ROWS - 1));

    assign res.cell_char  = rd_char_reg;
    assign res.cell_attr  = rd_attr_reg;
    assign res.cursor_row = ROW_FIELD_W'(cur_row_reg);
    assign res.cursor_col = COL_FIELD_W'(cur_col_reg);
    assign res.did_scroll = scroll_reg;

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        char_next       = char_reg;
        rrow_next       = rrow_reg;
        rcol_next       = rcol_reg;
        in_range_next   = in_range_reg;
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        top_next        = top_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_col_next  = sweep_col_reg;
        scroll_next     = scroll_reg;
        rd_char_next    = rd_char_reg;
        rd_attr_next    = rd_attr_reg;
        mem_req         = '0;

        if (accept)
        begin
            mode_next     = mode;
            char_next     = char_code;
            in_range_next = req_in_range;
            rrow_next     = req_in_range ? ROW_W'(read_row) : '0;
            rcol_next     = req_in_range ? COL_W'(read_col) : '0;
        end

        case (state_reg)
            S_INIT:
            begin
                mem_req.we      = 1'b1;
                mem_req.waddr   = sweep_addr_reg;
                mem_req.wdata   = {ATTR_RESET, BLANK_CODE};
                sweep_addr_next = sweep_addr_reg + 1'b1;
                if (sweep_addr_reg == ADDR_W'(NUM_CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                scroll_next  = 1'b0;
                rd_char_next = '0;
                rd_attr_next = '0;
                case (mode_reg)
                    MODE_PUT:
                    begin
                        scroll_next = scroll;
                        if (!is_nl)
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = cell_addr(phys_row(top_reg, cur_row_reg),
                                                      cur_col_reg);
                            mem_req.wdata = {attr, char_reg};
                        end
                        cur_col_next = adv_row ? '0 : cur_col_reg + 1'b1;
                        if (adv_row && !scroll)
                        begin
                            cur_row_next = cur_row_reg + 1'b1;
                        end
                        if (scroll)
                        begin
                            sweep_addr_next = cell_addr(top_reg, '0);
                            sweep_col_next  = '0;
                            state_next      = S_SCROLL;
                        end
                        else
                        begin
                            state_next = S_POST;
                        end
                    end
                    MODE_READ:
                    begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = cell_addr(phys_row(top_reg, rrow_reg), rcol_reg);
                        state_next    = S_RWAIT;
                    end
                    MODE_CLEAR:
                    begin
                        sweep_addr_next = '0;
                        state_next      = S_CLEAR;
                    end
                    default:
                    begin
                        state_next = S_POST;
                    end
                endcase
            end
            S_RWAIT:
            begin
                rd_char_next = in_range_reg ? rdata[CHAR_W-1:0] : '0;
                rd_attr_next = in_range_reg ? rdata[CELL_W-1:CHAR_W] : '0;
                state_next   = S_POST;
            end
            S_CLEAR:
            begin
                mem_req.we      = 1'b1;
                mem_req.waddr   = sweep_addr_reg;
                mem_req.wdata   = blank;
                sweep_addr_next = sweep_addr_reg + 1'b1;
                if (sweep_addr_reg == ADDR_W'(NUM_CELLS - 1))
                begin
                    state_next = S_POST;
                end
            end
            S_SCROLL:
            begin
                // old top row becomes the blank bottom row
                mem_req.we      = 1'b1;
                mem_req.waddr   = sweep_addr_reg;
                mem_req.wdata   = blank;
                sweep_addr_next = sweep_addr_reg + 1'b1;
                sweep_col_next  = sweep_col_reg + 1'b1;
                if (sweep_col_reg == COL_W'(COLUMNS - 1))
                begin
                    top_next   = (top_reg == ROW_W'(ROWS - 1)) ? '0 : top_reg + 1'b1;
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                if (slot_free)
                begin
                    state_next = accept ? S_EXEC : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            top_reg        <= '0;
            sweep_addr_reg <= '0;
            sweep_col_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_row_reg    <= cur_row_next;
            cur_col_reg    <= cur_col_next;
            top_reg        <= top_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_col_reg  <= sweep_col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        char_reg     <= char_next;
        rrow_reg     <= rrow_next;
        rcol_reg     <= rcol_next;
        in_range_reg <= in_range_next;
        scroll_reg   <= scroll_next;
        rd_char_reg  <= rd_char_next;
        rd_attr_reg  <= rd_attr_next;
    end

endmodule

### rtl/core/text_console_writer.sv
// Put: EXEC, POST, then the output register; a scrolling put adds a SCROLL
// sweep, one blank write per column. Read: EXEC, RWAIT, POST. Clear: one
// cell write per cycle on the memory port. A new request is taken in idle,
// or in POST with a free output slot. Reset: cursor home, attribute 15;
// in_ready low while cells are blanked. Config writes are taken at any time.
module text_console_writer
    import tcw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [MODE_W-1:0]      mode,
    input  logic [CHAR_W-1:0]      char_code,
    input  logic [ROW_FIELD_W-1:0] read_row,
    input  logic [COL_FIELD_W-1:0] read_col,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [CHAR_W-1:0]      cell_char,
    output logic [ATTR_W-1:0]      cell_attr,
    output logic [ROW_FIELD_W-1:0] cursor_row,
    output logic [COL_FIELD_W-1:0] cursor_col,
    output logic                   did_scroll,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [ATTR_W-1:0]      text_attribute
);

    logic [ATTR_W-1:0] attr_reg;
    logic              out_valid_reg;
    result_t           out_reg;
    logic              slot_free;
    logic              res_valid;
    result_t           res;
    mem_req_t          mem_req;
    logic [CELL_W-1:0] rdata;

    assign cfg_ready = 1'b1;
    assign slot_free = !out_valid_reg || out_ready;

    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .char_code (char_code),
        .read_row  (read_row),
        .read_col  (read_col),
        .attr      (attr_reg),
        .slot_free (slot_free),
        .res_valid (res_valid),
        .res       (res),
        .mem_req   (mem_req),
        .rdata     (rdata)
    );

    tcw_ram #(
        .DEPTH (NUM_CELLS),
        .WIDTH (CELL_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg      <= ATTR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                attr_reg <= text_attribute;
            end
            if (slot_free)
            begin
                out_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_char  = out_reg.cell_char;
    assign cell_attr  = out_reg.cell_attr;
    assign cursor_row = out_reg.cursor_row;
    assign cursor_col = out_reg.cursor_col;
    assign did_scroll = out_reg.did_scroll;

endmodule

### rtl/core/tcw_checker.sv
// Port-level checks for the text console writer, bound to the top level.
module tcw_checker
    import tcw_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [CHAR_W-1:0]      cell_char,
    input logic [ATTR_W-1:0]      cell_attr,
    input logic [ROW_FIELD_W-1:0] cursor_row,
    input logic [COL_FIELD_W-1:0] cursor_col,
    input logic                   did_scroll
);

    a_one_request_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while previous one still in flight");

    a_cursor_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(cursor_row) < ROWS) && (32'(cursor_col) < COLUMNS))
        else $error("cursor outside the grid");

    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && did_scroll |->
            (cursor_col == '0) && (cursor_row == ROW_FIELD_W'(ROWS - 1))
            && (cell_char == '0) && (cell_attr == '0))
        else $error("scroll result with wrong cursor or cell data");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({cell_char, cell_attr, cursor_row, cursor_col, did_scroll}))
        else $error("stalled result changed");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cell_char  (cell_char),
    .cell_attr  (cell_attr),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col),
    .did_scroll (did_scroll)
);
